/* rtl/core/lzfpt_pkg.sv */
package lzfpt_pkg;

  localparam int ZOOM_POINTS_DEF = 32;
  localparam int POS_WIDTH_DEF   = 16;

  localparam logic [3:0] COARSE_STEP = 4'd10;
  localparam logic [3:0] FINE_STEP   = 4'd1;

  localparam logic [1:0] HS_IDLE   = 2'd0;
  localparam logic [1:0] HS_SEARCH = 2'd1;
  localparam logic [1:0] HS_DONE   = 2'd2;
  localparam logic [1:0] HS_FAIL   = 2'd3;

  localparam logic [2:0] REG_FOCUS_LO    = 3'd0;
  localparam logic [2:0] REG_FOCUS_HI    = 3'd1;
  localparam logic [2:0] REG_ZOOM_LO     = 3'd2;
  localparam logic [2:0] REG_ZOOM_HI     = 3'd3;
  localparam logic [2:0] REG_FOCUS_HOME  = 3'd4;
  localparam logic [2:0] REG_ZOOM_HOME   = 3'd5;
  localparam logic [2:0] REG_FOCUS_RANGE = 3'd6;
  localparam logic [2:0] REG_ZOOM_RANGE  = 3'd7;

  typedef enum logic [3:0] {
    OP_INIT      = 4'd0,
    OP_SET_DIR   = 4'd1,
    OP_MOVE_REL  = 4'd2,
    OP_SET_POINT = 4'd3,
    OP_POINT_UP  = 4'd4,
    OP_POINT_DN  = 4'd5,
    OP_LOAD_ZOOM = 4'd6,
    OP_LOAD_FOC  = 4'd7,
    OP_HOME_GO   = 4'd8,
    OP_HOME_TICK = 4'd9,
    OP_STATUS    = 4'd10
  } op_t;

  typedef enum logic [3:0] {
    K_NOP, K_INIT, K_DIR, K_MOVE, K_POINT, K_UP, K_DOWN,
    K_LDZ, K_LDF, K_HSTART, K_HTICK
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        axis;
    logic [15:0] value;
    logic [4:0]  tidx;
    logic        pi;
    logic        err;
  } cmd_t;

  typedef struct packed {
    logic [15:0] focus_lo;
    logic [15:0] focus_hi;
    logic [15:0] zoom_lo;
    logic [15:0] zoom_hi;
    logic [15:0] focus_home;
    logic [15:0] zoom_home;
    logic [15:0] focus_range;
    logic [15:0] zoom_range;
  } cfg_t;

endpackage

/* rtl/core/lzfpt_ram.sv */
module lzfpt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/lzfpt_front.sv */
module lzfpt_front #(
  parameter int ZOOM_POINTS = lzfpt_pkg::ZOOM_POINTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [3:0]        operation,
  input  logic              axis,
  input  logic [15:0]       value,
  input  logic [4:0]        table_index,
  input  logic              pi_flag,
  output logic              push,
  output lzfpt_pkg::cmd_t   push_cmd,
  input  logic              q_full
);

  logic            fv;
  lzfpt_pkg::cmd_t cmd;
  lzfpt_pkg::cmd_t cmd_next;
  logic            accept;
  logic            tidx_bad;

  assign in_stall = fv & q_full;
  assign accept   = in_valid & ~in_stall;
  assign push     = fv & ~q_full;
  assign push_cmd = cmd;
  assign tidx_bad = {27'd0, table_index} >= 32'(ZOOM_POINTS);

  always_comb begin
    cmd_next.kind  = lzfpt_pkg::K_NOP;
    cmd_next.axis  = axis;
    cmd_next.value = value;
    cmd_next.tidx  = table_index;
    cmd_next.pi    = pi_flag;
    cmd_next.err   = 1'b0;
    unique case (lzfpt_pkg::op_t'(operation))
      lzfpt_pkg::OP_INIT:      cmd_next.kind = lzfpt_pkg::K_INIT;
      lzfpt_pkg::OP_SET_DIR:   cmd_next.kind = lzfpt_pkg::K_DIR;
      lzfpt_pkg::OP_MOVE_REL:  cmd_next.kind = lzfpt_pkg::K_MOVE;
      lzfpt_pkg::OP_SET_POINT: begin
        if ({16'd0, value} >= 32'(ZOOM_POINTS)) begin
          cmd_next.err = 1'b1;
        end else begin
          cmd_next.kind = lzfpt_pkg::K_POINT;
        end
      end
      lzfpt_pkg::OP_POINT_UP:  cmd_next.kind = lzfpt_pkg::K_UP;
      lzfpt_pkg::OP_POINT_DN:  cmd_next.kind = lzfpt_pkg::K_DOWN;
      lzfpt_pkg::OP_LOAD_ZOOM: begin
        if (tidx_bad) cmd_next.err = 1'b1;
        else cmd_next.kind = lzfpt_pkg::K_LDZ;
      end
      lzfpt_pkg::OP_LOAD_FOC: begin
        if (tidx_bad) cmd_next.err = 1'b1;
        else cmd_next.kind = lzfpt_pkg::K_LDF;
      end
      lzfpt_pkg::OP_HOME_GO:   cmd_next.kind = lzfpt_pkg::K_HSTART;
      lzfpt_pkg::OP_HOME_TICK: cmd_next.kind = lzfpt_pkg::K_HTICK;
      lzfpt_pkg::OP_STATUS:    cmd_next.kind = lzfpt_pkg::K_NOP;
      default:                 cmd_next.err  = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else begin
      fv <= accept | (fv & ~push);
    end
    if (accept) begin
      cmd <= cmd_next;
    end
  end

endmodule

/* rtl/core/lzfpt_queue.sv */
module lzfpt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lzfpt_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            nonempty,
  output lzfpt_pkg::cmd_t head
);

  lzfpt_pkg::cmd_t slot [2];
  logic            wptr;
  logic            rptr;
  logic [1:0]      count;

  assign full     = count[1];
  assign nonempty = count != 2'd0;
  assign head     = slot[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      slot[wptr] <= push_cmd;
    end
  end

endmodule

/* rtl/core/lzfpt_back.sv */
module lzfpt_back #(
  parameter int ZOOM_POINTS = lzfpt_pkg::ZOOM_POINTS_DEF,
  parameter int POS_WIDTH   = lzfpt_pkg::POS_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lzfpt_pkg::cfg_t                cfg,
  input  logic                           q_nonempty,
  input  lzfpt_pkg::cmd_t                q_cmd,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [POS_WIDTH-1:0]           o_focus_steps,
  output logic                           o_focus_reverse,
  output logic [POS_WIDTH-1:0]           o_zoom_steps,
  output logic                           o_zoom_reverse,
  output logic [POS_WIDTH-1:0]           o_focus_position,
  output logic [POS_WIDTH-1:0]           o_zoom_position,
  output logic [$clog2(ZOOM_POINTS)-1:0] o_current_point,
  output logic [1:0]                     o_home_status,
  output logic                           o_error
);

  localparam int P  = POS_WIDTH;
  localparam int PW = $clog2(ZOOM_POINTS);
  localparam int MW = (P > 16) ? P : 16;
  localparam int SW = MW + 1;

  typedef enum logic {B_IDLE, B_EXEC} bstate_t;

  bstate_t         state;
  lzfpt_pkg::cmd_t cmd;
  logic [P-1:0]    fpos, zpos, fpos_next, zpos_next;
  logic            fdir, zdir, fdir_next, zdir_next;
  logic [PW-1:0]   point, point_next, pt_eff, rd_addr, raddr_q;
  logic [1:0]      hphase, hphase_next;
  logic            haxis, haxis_next, href, href_next, hfine, hfine_next;
  logic [16:0]     hcount, hcount_next, hbase;
  logic [ZOOM_POINTS-1:0] fvalid;

  logic            done, exec_done, wr_z, wr_f;
  logic [15:0]     zrd, frd, ftab;
  logic [P-1:0]    flo, fhi, zlo, zhi, fhome, zhome;
  logic [SW-1:0]   zsum;
  logic [P-1:0]    zt, ft, zmag, fmag;
  logic [P:0]      zd, fd;
  logic            zdt, fdt, go, hd, hdir;
  logic [3:0]      hstep;
  logic [15:0]     hrange;
  logic [P-1:0]    fs, zs;
  logic            frev, zrev;

  function automatic logic [P-1:0] clamp_drive(logic [P-1:0] pos, logic [MW-1:0] steps,
                                               logic rev, logic [P-1:0] lo,
                                               logic [P-1:0] hi);
    logic [P-1:0] room;
    if (rev) room = (pos < hi) ? hi - pos : '0;
    else room = (pos > lo) ? pos - lo : '0;
    if (steps > MW'(room)) return room;
    return P'(steps);
  endfunction

  assign flo   = P'(cfg.focus_lo);
  assign fhi   = P'(cfg.focus_hi);
  assign zlo   = P'(cfg.zoom_lo);
  assign zhi   = P'(cfg.zoom_hi);
  assign fhome = P'(cfg.focus_home);
  assign zhome = P'(cfg.zoom_home);

  assign done      = ~out_valid | ~out_stall;
  assign exec_done = (state == B_EXEC) & done;
  assign q_pop     = q_nonempty & ((state == B_IDLE) | exec_done);
  assign pt_eff    = exec_done ? point_next : point;
  assign wr_z      = q_pop & (q_cmd.kind == lzfpt_pkg::K_LDZ);
  assign wr_f      = q_pop & (q_cmd.kind == lzfpt_pkg::K_LDF);

  always_comb begin
    unique case (q_cmd.kind)
      lzfpt_pkg::K_POINT: rd_addr = PW'(q_cmd.value);
      lzfpt_pkg::K_UP:    rd_addr = pt_eff + PW'(1);
      lzfpt_pkg::K_DOWN:  rd_addr = pt_eff - PW'(1);
      default:            rd_addr = '0;
    endcase
  end

  lzfpt_ram #(.WIDTH(16), .DEPTH(ZOOM_POINTS)) u_zoom_tab (
    .clk(clk), .we(wr_z), .waddr(PW'(q_cmd.tidx)), .wdata(q_cmd.value),
    .re(q_pop), .raddr(rd_addr), .rdata(zrd)
  );

  lzfpt_ram #(.WIDTH(16), .DEPTH(ZOOM_POINTS)) u_focus_tab (
    .clk(clk), .we(wr_f), .waddr(PW'(q_cmd.tidx)), .wdata(q_cmd.value),
    .re(q_pop), .raddr(rd_addr), .rdata(frd)
  );

  assign ftab = fvalid[raddr_q] ? frd : 16'd0;

  // zoom-point targets
  assign zsum = SW'(zrd) + SW'(zhome);
  assign zt   = (zsum > SW'({P{1'b1}})) ? {P{1'b1}} : P'(zsum);
  assign ft   = P'(ftab);
  assign zd   = {1'b0, zt} - {1'b0, zpos};
  assign fd   = {1'b0, ft} - {1'b0, fpos};
  assign zdt  = ~zd[P];
  assign fdt  = ~fd[P];
  assign zmag = zd[P] ? P'(-zd) : zd[P-1:0];
  assign fmag = fd[P] ? P'(-fd) : fd[P-1:0];

  always_comb begin
    fpos_next   = fpos;
    zpos_next   = zpos;
    fdir_next   = fdir;
    zdir_next   = zdir;
    point_next  = point;
    hphase_next = hphase;
    haxis_next  = haxis;
    href_next   = href;
    hfine_next  = hfine;
    hcount_next = hcount;
    hbase       = hcount;
    fs          = '0;
    zs          = '0;
    go          = 1'b0;
    hd          = 1'b0;
    hdir        = 1'b0;
    hstep       = lzfpt_pkg::FINE_STEP;
    unique case (cmd.kind)
      lzfpt_pkg::K_INIT: begin
        point_next = '0;
        zdir_next  = zdt;
        zs         = clamp_drive(zpos, MW'(zmag), zdt, zlo, zhi);
        zpos_next  = zdt ? zpos + zs : zpos - zs;
        fdir_next  = fdt;
        fs         = clamp_drive(fpos, MW'(fmag), fdt, flo, fhi);
        fpos_next  = fdt ? fpos + fs : fpos - fs;
      end
      lzfpt_pkg::K_DIR: begin
        if (cmd.axis) zdir_next = cmd.value[0];
        else fdir_next = cmd.value[0];
      end
      lzfpt_pkg::K_MOVE: begin
        if (cmd.axis) begin
          zs        = clamp_drive(zpos, MW'(cmd.value), zdir, zlo, zhi);
          zpos_next = zdir ? zpos + zs : zpos - zs;
        end else begin
          fs        = clamp_drive(fpos, MW'(cmd.value), fdir, flo, fhi);
          fpos_next = fdir ? fpos + fs : fpos - fs;
        end
      end
      lzfpt_pkg::K_POINT: begin
        point_next = PW'(cmd.value);
        go         = 1'b1;
      end
      lzfpt_pkg::K_UP: begin
        if ({1'b0, point} + (PW+1)'(1) < (PW+1)'(ZOOM_POINTS)) begin
          point_next = point + PW'(1);
          go         = 1'b1;
        end
      end
      lzfpt_pkg::K_DOWN: begin
        if (point != '0) begin
          point_next = point - PW'(1);
          go         = 1'b1;
        end
      end
      lzfpt_pkg::K_HSTART: begin
        haxis_next  = cmd.axis;
        href_next   = cmd.pi;
        hfine_next  = 1'b0;
        hphase_next = lzfpt_pkg::HS_SEARCH;
        hbase       = '0;
        hd          = 1'b1;
        hdir        = ~cmd.pi;
        hstep       = lzfpt_pkg::COARSE_STEP;
      end
      lzfpt_pkg::K_HTICK: begin
        if (hphase == lzfpt_pkg::HS_SEARCH) begin
          if (!hfine) begin
            hd = 1'b1;
            if (cmd.pi != href) begin
              hfine_next = 1'b1;
              href_next  = cmd.pi;
              hbase      = '0;
              hdir       = ~cmd.pi;
            end else begin
              hdir  = ~href;
              hstep = lzfpt_pkg::COARSE_STEP;
            end
          end else if (cmd.pi != href) begin
            if (!href) begin
              href_next = 1'b1;
              hbase     = '0;
              hd        = 1'b1;
            end else begin
              hphase_next = lzfpt_pkg::HS_DONE;
              if (haxis) zpos_next = zhome;
              else fpos_next = fhome;
            end
          end else begin
            hd   = 1'b1;
            hdir = ~href;
          end
        end
      end
      default: begin
      end
    endcase

    if (go) begin
      zdir_next = zdt;
      zpos_next = zt;
      zs        = zmag;
      fdir_next = fdt;
      fpos_next = ft;
      fs        = fmag;
    end

    hrange = haxis_next ? cfg.zoom_range : cfg.focus_range;
    frev   = fdir_next;
    zrev   = zdir_next;
    if (hd) begin
      hcount_next = hbase + 17'(hstep);
      if (hcount_next > {1'b0, hrange}) hphase_next = lzfpt_pkg::HS_FAIL;
      if (haxis_next) begin
        zs   = P'(hstep);
        zrev = hdir;
      end else begin
        fs   = P'(hstep);
        frev = hdir;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      fpos      <= '0;
      zpos      <= '0;
      fdir      <= 1'b0;
      zdir      <= 1'b0;
      point     <= '0;
      hphase    <= lzfpt_pkg::HS_IDLE;
      haxis     <= 1'b0;
      href      <= 1'b0;
      hfine     <= 1'b0;
      hcount    <= '0;
      fvalid    <= '0;
    end else begin
      if (wr_f) fvalid[PW'(q_cmd.tidx)] <= 1'b1;
      if (q_pop) state <= B_EXEC;
      else if (exec_done) state <= B_IDLE;
      if (exec_done) begin
        out_valid <= 1'b1;
        fpos      <= fpos_next;
        zpos      <= zpos_next;
        fdir      <= fdir_next;
        zdir      <= zdir_next;
        point     <= point_next;
        hphase    <= hphase_next;
        haxis     <= haxis_next;
        href      <= href_next;
        hfine     <= hfine_next;
        hcount    <= hcount_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (q_pop) begin
      cmd     <= q_cmd;
      raddr_q <= rd_addr;
    end
    if (exec_done) begin
      o_focus_steps    <= fs;
      o_focus_reverse  <= frev;
      o_zoom_steps     <= zs;
      o_zoom_reverse   <= zrev;
      o_focus_position <= fpos_next;
      o_zoom_position  <= zpos_next;
      o_current_point  <= point_next;
      o_home_status    <= hphase_next;
      o_error          <= cmd.err;
    end
  end

endmodule

/* rtl/core/lens_zoom_focus_position_tracker_top.sv */
// Lens focus/zoom position tracker and step commander.
// Input channel: in_valid/in_stall with operation, axis, value, table_index
// and pi_flag; one word is taken at each edge with in_valid high and
// in_stall low. Output channel: out_valid/out_stall, one result word per
// input word, in order, carrying step counts, directions, positions, the
// zoom point, homing status and error.
// Each word passes the classify, queue and execute stages in order.
// Throughput is one word per cycle while out_stall is low: the execute
// unit reads the zoom and focus tables as a word leaves the queue and
// updates the position registers when it executes that word, overlapped
// with the table read for the following word.
// A two-entry queue sits between the input classifier and the execute unit.
// When out_stall is held, the result holds, the execute unit waits, the
// queue fills and in_stall rises.
// Registers sit on an APB port at byte address 4*i; write only while idle.
// Reset clears positions, directions, zoom point, homing state and the focus
// table; the zoom table must be loaded before any point is used.
module lens_zoom_focus_position_tracker_top #(
  parameter int ZOOM_POINTS = lzfpt_pkg::ZOOM_POINTS_DEF,
  parameter int POS_WIDTH   = lzfpt_pkg::POS_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [4:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [3:0]                     operation,
  input  logic                           axis,
  input  logic [15:0]                    value,
  input  logic [4:0]                     table_index,
  input  logic                           pi_flag,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [POS_WIDTH-1:0]           focus_steps,
  output logic                           focus_reverse,
  output logic [POS_WIDTH-1:0]           zoom_steps,
  output logic                           zoom_reverse,
  output logic [POS_WIDTH-1:0]           focus_position,
  output logic [POS_WIDTH-1:0]           zoom_position,
  output logic [$clog2(ZOOM_POINTS)-1:0] current_point,
  output logic [1:0]                     home_status,
  output logic                           error
);

  lzfpt_pkg::cfg_t cfg;
  lzfpt_pkg::cmd_t push_cmd, head;
  logic            push, q_full, q_pop, q_nonempty, wr_en;
  logic [15:0]     rd_val;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focus_lo    <= 16'd0;
      cfg.focus_hi    <= 16'hFFFF;
      cfg.zoom_lo     <= 16'd0;
      cfg.zoom_hi     <= 16'hFFFF;
      cfg.focus_home  <= 16'd0;
      cfg.zoom_home   <= 16'd0;
      cfg.focus_range <= 16'hFFFF;
      cfg.zoom_range  <= 16'hFFFF;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        lzfpt_pkg::REG_FOCUS_LO:    cfg.focus_lo    <= pwdata[15:0];
        lzfpt_pkg::REG_FOCUS_HI:    cfg.focus_hi    <= pwdata[15:0];
        lzfpt_pkg::REG_ZOOM_LO:     cfg.zoom_lo     <= pwdata[15:0];
        lzfpt_pkg::REG_ZOOM_HI:     cfg.zoom_hi     <= pwdata[15:0];
        lzfpt_pkg::REG_FOCUS_HOME:  cfg.focus_home  <= pwdata[15:0];
        lzfpt_pkg::REG_ZOOM_HOME:   cfg.zoom_home   <= pwdata[15:0];
        lzfpt_pkg::REG_FOCUS_RANGE: cfg.focus_range <= pwdata[15:0];
        lzfpt_pkg::REG_ZOOM_RANGE:  cfg.zoom_range  <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      lzfpt_pkg::REG_FOCUS_LO:    rd_val = cfg.focus_lo;
      lzfpt_pkg::REG_FOCUS_HI:    rd_val = cfg.focus_hi;
      lzfpt_pkg::REG_ZOOM_LO:     rd_val = cfg.zoom_lo;
      lzfpt_pkg::REG_ZOOM_HI:     rd_val = cfg.zoom_hi;
      lzfpt_pkg::REG_FOCUS_HOME:  rd_val = cfg.focus_home;
      lzfpt_pkg::REG_ZOOM_HOME:   rd_val = cfg.zoom_home;
      lzfpt_pkg::REG_FOCUS_RANGE: rd_val = cfg.focus_range;
      lzfpt_pkg::REG_ZOOM_RANGE:  rd_val = cfg.zoom_range;
      default:                    rd_val = 16'd0;
    endcase
  end

  assign prdata = {16'd0, rd_val};

  lzfpt_front #(.ZOOM_POINTS(ZOOM_POINTS)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .axis(axis), .value(value),
    .table_index(table_index), .pi_flag(pi_flag),
    .push(push), .push_cmd(push_cmd), .q_full(q_full)
  );

  lzfpt_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_cmd(push_cmd), .full(q_full),
    .pop(q_pop), .nonempty(q_nonempty), .head(head)
  );

  lzfpt_back #(.ZOOM_POINTS(ZOOM_POINTS), .POS_WIDTH(POS_WIDTH)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_nonempty(q_nonempty), .q_cmd(head),
    .q_pop(q_pop), .out_valid(out_valid), .out_stall(out_stall),
    .o_focus_steps(focus_steps), .o_focus_reverse(focus_reverse),
    .o_zoom_steps(zoom_steps), .o_zoom_reverse(zoom_reverse),
    .o_focus_position(focus_position), .o_zoom_position(zoom_position),
    .o_current_point(current_point), .o_home_status(home_status),
    .o_error(error)
  );

endmodule

/* rtl/core/lzfpt_checker.sv */
module lzfpt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] focus_steps,
  input logic [15:0] zoom_steps,
  input logic [15:0] focus_position,
  input logic        error
);

  a_out_idle_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid right after reset");

  a_in_open_after_reset: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled right after reset");

  a_err_no_steps: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error) |-> (focus_steps == 16'd0 && zoom_steps == 16'd0))
    else $error("rejected word drives steps");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(focus_position)))
    else $error("stalled output word changed");

endmodule

bind lens_zoom_focus_position_tracker_top lzfpt_checker u_lzfpt_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .focus_steps(focus_steps[15:0]),
  .zoom_steps(zoom_steps[15:0]), .focus_position(focus_position[15:0]),
  .error(error)
);
